>>> hw/rtl/led_matrix_serial_framer_defines.svh
// ----------------------------------------------------------------------------
// LED matrix serial framer assertion macros
// Concurrent check macros; they expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SERIAL_FRAMER_DEFINES_SVH
`define LED_MATRIX_SERIAL_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define LMSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LMSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LMSF_ASSERT_IMP(lbl, ante, cons, msg)
`define LMSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/lmsf_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix serial framer package
// Payload types, command codes and the sequencer microprogram.
// ----------------------------------------------------------------------------
package lmsf_pkg;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_STOP   = 2'd1,
    FUNC_BRIGHT = 2'd2,
    FUNC_DATA   = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [4:0] column;
    logic [7:0] left_byte;
    logic [7:0] right_byte;
    logic [3:0] level;
  } op_t;

  typedef struct packed {
    logic left_bit;
    logic right_bit;
    logic frame_first;
    logic last;
  } sym_t;

  localparam logic [2:0] PREFIX_CMD      = 3'b100;
  localparam logic [2:0] PREFIX_DATA     = 3'b101;
  localparam logic [7:0] CMD_SYS_DISABLE = 8'h00;
  localparam logic [7:0] CMD_SYS_ENABLE  = 8'h01;
  localparam logic [7:0] CMD_NMOS_8COM   = 8'h20;
  localparam logic [7:0] CMD_LED_ON      = 8'h03;
  localparam logic [7:0] CMD_BRIGHT      = 8'hA0;
  localparam logic [7:0] CMD_BRIGHT_MAX  = 8'hAF;

  localparam int SEG_W = 9;

  typedef enum logic [2:0] {
    SRC_PREFIX,
    SRC_CONST,
    SRC_BRIGHT,
    SRC_ADDR,
    SRC_LO,
    SRC_HI
  } src_t;

  typedef logic [3:0] step_t;

  localparam step_t ST_PREFIX   = 4'd0;
  localparam step_t ST_START_0  = 4'd1;
  localparam step_t ST_START_1  = 4'd2;
  localparam step_t ST_START_2  = 4'd3;
  localparam step_t ST_START_3  = 4'd4;
  localparam step_t ST_START_4  = 4'd5;
  localparam step_t ST_STOP     = 4'd6;
  localparam step_t ST_BRIGHT   = 4'd7;
  localparam step_t ST_DATA_A   = 4'd8;
  localparam step_t ST_DATA_LO  = 4'd9;
  localparam step_t ST_DATA_HI  = 4'd10;

  typedef struct packed {
    src_t       src;
    logic [7:0] konst;
    logic [3:0] nbits;
    logic       dispatch;
    logic       final_seg;
    step_t      nxt;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    w = '{src: SRC_CONST, konst: 8'h00, nbits: 4'd9, dispatch: 1'b0,
          final_seg: 1'b0, nxt: ST_PREFIX};
    unique case (s)
      ST_PREFIX: begin
        w.src      = SRC_PREFIX;
        w.nbits    = 4'd3;
        w.dispatch = 1'b1;
      end
      ST_START_0: begin
        w.konst = CMD_SYS_DISABLE;
        w.nxt   = ST_START_1;
      end
      ST_START_1: begin
        w.konst = CMD_NMOS_8COM;
        w.nxt   = ST_START_2;
      end
      ST_START_2: begin
        w.konst = CMD_SYS_ENABLE;
        w.nxt   = ST_START_3;
      end
      ST_START_3: begin
        w.konst = CMD_LED_ON;
        w.nxt   = ST_START_4;
      end
      ST_START_4: begin
        w.konst     = CMD_BRIGHT_MAX;
        w.final_seg = 1'b1;
      end
      ST_STOP: begin
        w.konst     = CMD_SYS_DISABLE;
        w.final_seg = 1'b1;
      end
      ST_BRIGHT: begin
        w.src       = SRC_BRIGHT;
        w.final_seg = 1'b1;
      end
      ST_DATA_A: begin
        w.src   = SRC_ADDR;
        w.nbits = 4'd7;
        w.nxt   = ST_DATA_LO;
      end
      ST_DATA_LO: begin
        w.src   = SRC_LO;
        w.nbits = 4'd4;
        w.nxt   = ST_DATA_HI;
      end
      ST_DATA_HI: begin
        w.src       = SRC_HI;
        w.nbits     = 4'd4;
        w.final_seg = 1'b1;
      end
      default: begin
        w.final_seg = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/lmsf_sequencer.sv
// ----------------------------------------------------------------------------
// LED matrix serial framer sequencer
// Step counter over the microprogram, with a dispatch jump on the operation.
// ----------------------------------------------------------------------------
module lmsf_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 seg_done,
  input  lmsf_pkg::func_t      func,
  output lmsf_pkg::ctrl_word_t word
);

  lmsf_pkg::step_t      step;
  lmsf_pkg::step_t      step_next;
  lmsf_pkg::ctrl_word_t cur;

  assign cur = lmsf_pkg::ucode(step);

  always_comb begin
    step_next = step;
    priority if (load) begin
      step_next = lmsf_pkg::ST_PREFIX;
    end else if (seg_done) begin
      if (cur.dispatch) begin
        unique case (func)
          lmsf_pkg::FUNC_START:  step_next = lmsf_pkg::ST_START_0;
          lmsf_pkg::FUNC_STOP:   step_next = lmsf_pkg::ST_STOP;
          lmsf_pkg::FUNC_BRIGHT: step_next = lmsf_pkg::ST_BRIGHT;
          lmsf_pkg::FUNC_DATA:   step_next = lmsf_pkg::ST_DATA_A;
          default:               step_next = lmsf_pkg::ST_PREFIX;
        endcase
      end else begin
        step_next = cur.nxt;
      end
    end else begin
      step_next = step;
    end
  end

  assign word = lmsf_pkg::ucode(step_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lmsf_pkg::ST_PREFIX;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> hw/rtl/led_matrix_serial_framer.sv
// ----------------------------------------------------------------------------
// LED matrix serial framer
// Turns one operation into the serial frame for the left and right chips.
//
//   channel  direction  handshake              payload
//   op       in         op_valid / op_ready    lmsf_pkg::op_t
//   sym      out        sym_valid / sym_ready  lmsf_pkg::sym_t
//
// An operation is taken, then one frame bit per cycle while the output is not
// held: 12 bits for stop and brightness, 18 for a data write, 48 for start.
// The bits come from two 9-bit shift segments, left and right, fed by the sequencer.
// A held output register stalls the shifter; the next operation is taken as
// soon as the final bit is in the output register.
// Reset clears the busy flag, the step counter and the output valid.
// ----------------------------------------------------------------------------
`include "led_matrix_serial_framer_defines.svh"

module led_matrix_serial_framer (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  output logic            op_ready,
  input  lmsf_pkg::op_t   op,
  output logic            sym_valid,
  input  logic            sym_ready,
  output lmsf_pkg::sym_t  sym
);

  logic                        busy;
  logic                        first;
  logic                        seg_final;
  logic [3:0]                  cnt;
  logic [lmsf_pkg::SEG_W-1:0]  sr_l;
  logic [lmsf_pkg::SEG_W-1:0]  sr_r;
  lmsf_pkg::op_t               item;
  lmsf_pkg::op_t               src_item;
  lmsf_pkg::ctrl_word_t        word;
  logic [lmsf_pkg::SEG_W-1:0]  load_l;
  logic [lmsf_pkg::SEG_W-1:0]  load_r;
  logic                        accept;
  logic                        adv;
  logic                        seg_done;
  logic                        last_bit;

  assign op_ready = !busy;
  assign accept   = op_valid && op_ready;
  assign adv      = busy && (!sym_valid || sym_ready);
  assign seg_done = adv && (cnt == 4'd1);
  assign last_bit = seg_final && (cnt == 4'd1);
  assign src_item = accept ? op : item;

  lmsf_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .seg_done (seg_done),
    .func     (item.func),
    .word     (word)
  );

  always_comb begin
    load_l = '0;
    load_r = '0;
    unique case (word.src)
      lmsf_pkg::SRC_PREFIX: begin
        load_l = {(src_item.func == lmsf_pkg::FUNC_DATA) ? lmsf_pkg::PREFIX_DATA
                                                          : lmsf_pkg::PREFIX_CMD, 6'b0};
        load_r = load_l;
      end
      lmsf_pkg::SRC_CONST: begin
        load_l = {word.konst, 1'b0};
        load_r = load_l;
      end
      lmsf_pkg::SRC_BRIGHT: begin
        load_l = {lmsf_pkg::CMD_BRIGHT | {4'b0, src_item.level}, 1'b0};
        load_r = load_l;
      end
      lmsf_pkg::SRC_ADDR: begin
        load_l = {1'b0, src_item.column, 1'b0, 2'b0};
        load_r = load_l;
      end
      lmsf_pkg::SRC_LO: begin
        load_l = {src_item.left_byte[0], src_item.left_byte[1],
                  src_item.left_byte[2], src_item.left_byte[3], 5'b0};
        load_r = {src_item.right_byte[0], src_item.right_byte[1],
                  src_item.right_byte[2], src_item.right_byte[3], 5'b0};
      end
      lmsf_pkg::SRC_HI: begin
        load_l = {src_item.left_byte[4], src_item.left_byte[5],
                  src_item.left_byte[6], src_item.left_byte[7], 5'b0};
        load_r = {src_item.right_byte[4], src_item.right_byte[5],
                  src_item.right_byte[6], src_item.right_byte[7], 5'b0};
      end
      default: begin
        load_l = '0;
        load_r = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sym_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (adv && last_bit) begin
        busy <= 1'b0;
      end
      if (adv) begin
        sym_valid <= 1'b1;
      end else if (sym_ready) begin
        sym_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= op;
    end
    if (adv) begin
      sym <= '{left_bit: sr_l[lmsf_pkg::SEG_W-1], right_bit: sr_r[lmsf_pkg::SEG_W-1],
               frame_first: first, last: last_bit};
    end
    if (accept || seg_done) begin
      sr_l      <= load_l;
      sr_r      <= load_r;
      cnt       <= word.nbits;
      seg_final <= word.final_seg;
    end else if (adv) begin
      sr_l <= {sr_l[lmsf_pkg::SEG_W-2:0], 1'b0};
      sr_r <= {sr_r[lmsf_pkg::SEG_W-2:0], 1'b0};
      cnt  <= cnt - 4'd1;
    end
    if (accept) begin
      first <= 1'b1;
    end else if (adv) begin
      first <= 1'b0;
    end
  end

  `LMSF_ASSERT_NXT(a_load_frame, accept, busy && first && (cnt == 4'd3), "frame must open with the prefix")
  `LMSF_ASSERT_IMP(a_cnt_live, busy, (cnt != 4'd0) && (cnt <= 4'd9), "segment count out of range while busy")
  `LMSF_ASSERT_NXT(a_last_frees, adv && last_bit, !busy && sym_valid && sym.last, "final bit must end the frame")

endmodule
